>>> src/sat_pkg.sv
`timescale 1ns / 1ps

package sat_pkg;

   // default geometry
   localparam int DEF_MAX_ROWS      = 64;
   localparam int DEF_MAX_COLS      = 64;
   localparam int DEF_ELEMENT_WIDTH = 16;

   // fixed field and storage widths
   localparam int CNT_W      = 7;
   localparam int COORD_W    = 6;
   localparam int RUN_W      = 22;
   localparam int TABLE_W    = 28;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CNT_W-1:0] ROW_COUNT_RESET = 7'd64;
   localparam logic [CNT_W-1:0] COL_COUNT_RESET = 7'd64;

   // register select, taken from paddr bit 2
   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

endpackage

>>> src/sat_req_if.sv
`timescale 1ns / 1ps

interface sat_req_if #(
   parameter int ELEMENT_WIDTH = sat_pkg::DEF_ELEMENT_WIDTH
);
   import sat_pkg::*;

   logic                            valid;
   logic                            ready;
   kind_type                        kind;
   logic signed [ELEMENT_WIDTH-1:0] element_value;
   logic [COORD_W-1:0]              start_row;
   logic [COORD_W-1:0]              start_col;
   logic [COORD_W-1:0]              end_row;
   logic [COORD_W-1:0]              end_col;

   modport source (
      output valid, kind, element_value, start_row, start_col, end_row, end_col,
      input  ready
   );

   modport sink (
      input  valid, kind, element_value, start_row, start_col, end_row, end_col,
      output ready
   );

endinterface

>>> src/sat_rsp_if.sv
`timescale 1ns / 1ps

interface sat_rsp_if;
   import sat_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [TABLE_W-1:0] rect_sum;
   logic                      query_error;

   modport source (
      output valid, rect_sum, query_error,
      input  ready
   );

   modport sink (
      input  valid, rect_sum, query_error,
      output ready
   );

endinterface

>>> src/summed_area_table_rect_sum.sv
`timescale 1ns / 1ps

// Summed-area table with rectangle-sum queries. Load transfers (kind 0) carry matrix
// elements in row-major order; each one is folded into a running row sum and stored as
// entry(r,c) = entry(r-1,c) + row sum, in a single-port table memory of
// MAX_ROWS x MAX_COLS words of 28 bits (one read or one write per cycle, read data
// registered). Query transfers (kind 1) return the sum over the inclusive rectangle from
// the four usual corners, or query_error with a zero sum when the table is not fully
// loaded, an end coordinate is not below the count in use, or a start lies past its end.
// Loads give no response. Items are handled one at a time: a load is accept, read
// of the entry above, write back; a valid query is accept, four corner reads through
// the one memory port, final add, response load; a rejected query is accept, then
// response load. A finished response sits in an output register, so the next item is
// accepted while it waits. Writing row_count (address 0) or col_count (address 4)
// restarts the load; a count of 0 acts as 1 and a count above the maximum acts as the
// maximum. The table needs no clearing after reset.
module summed_area_table_rect_sum #(
   parameter int MAX_ROWS      = sat_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS      = sat_pkg::DEF_MAX_COLS,
   parameter int ELEMENT_WIDTH = sat_pkg::DEF_ELEMENT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   sat_req_if.sink                           req_chan,
   sat_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sat_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sat_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sat_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import sat_pkg::*;

   // geometry derived from the parameters
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W    = $clog2(MAX_COLS + 1);
   localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   // compare widths for config counts and query coordinates
   localparam int RCFG_W    = (RCNT_W > CNT_W) ? RCNT_W : CNT_W;
   localparam int CCFG_W    = (CCNT_W > CNT_W) ? CCNT_W : CNT_W;
   localparam int RQ_W      = (RCNT_W > COORD_W) ? RCNT_W : COORD_W;
   localparam int CQ_W      = (CCNT_W > COORD_W) ? CCNT_W : COORD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_READ,
      ST_LD_WRITE,
      ST_Q_READ,
      ST_Q_LAST,
      ST_Q_DONE
   } state_type;

   // corner order of a query: bottom-right, top-right, bottom-left, top-left
   typedef enum logic [1:0] {
      CORNER_BR = 2'd0,
      CORNER_TR = 2'd1,
      CORNER_BL = 2'd2,
      CORNER_TL = 2'd3
   } corner_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
   endfunction

   // ---------------------------------------------------------------- registers
   state_type                 state_ff, state_in;
   corner_type                corner_ff, corner_in;
   logic [CNT_W-1:0]          row_cfg_ff, row_cfg_in;
   logic [CNT_W-1:0]          col_cfg_ff, col_cfg_in;
   logic [ROW_W-1:0]          load_row_ff, load_row_in;
   logic [COL_W-1:0]          load_col_ff, load_col_in;
   logic signed [RUN_W-1:0]   run_sum_ff, run_sum_in;
   logic                      full_ff, full_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TABLE_W-1:0]        rsp_sum_ff, rsp_sum_in;
   logic                      rsp_err_ff, rsp_err_in;
   // per-item working registers
   logic [ROW_W-1:0]          wr_row_ff, wr_row_in;
   logic [COL_W-1:0]          wr_col_ff, wr_col_in;
   logic [ROW_W-1:0]          q_sr_ff, q_sr_in;
   logic [COL_W-1:0]          q_sc_ff, q_sc_in;
   logic [ROW_W-1:0]          q_er_ff, q_er_in;
   logic [COL_W-1:0]          q_ec_ff, q_ec_in;
   logic                      q_err_ff, q_err_in;
   logic [TABLE_W-1:0]        acc_ff, acc_in;
   logic                      term_use_ff, term_use_in;
   logic                      term_neg_ff, term_neg_in;

   // table memory
   logic [TABLE_W-1:0]        table_mem [MEM_DEPTH];
   logic [TABLE_W-1:0]        rd_data_ff;
   logic                      mem_we;
   logic                      mem_re;
   logic [ADDR_W-1:0]         mem_addr;
   logic [TABLE_W-1:0]        mem_wdata;

   // ---------------------------------------------------------------- decode
   logic                      req_fire;
   logic                      csr_write;
   logic [RCNT_W-1:0]         rows_eff;
   logic [CCNT_W-1:0]         cols_eff;
   logic signed [ELEMENT_WIDTH-1:0] elem_value;

   // load position logic, evaluated in the accept cycle
   logic                      restart;
   logic [ROW_W-1:0]          ld_row;
   logic [COL_W-1:0]          ld_col;
   logic signed [RUN_W-1:0]   run_base;
   logic signed [RUN_W-1:0]   run_new;
   logic [CCNT_W-1:0]         col_next;
   logic [RCNT_W-1:0]         row_next;

   // query checks
   logic                      query_bad;

   // corner address decode
   logic [ROW_W-1:0]          corner_row;
   logic [COL_W-1:0]          corner_col;
   logic                      corner_use;
   logic                      corner_neg;
   logic [TABLE_W-1:0]        above;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign csr_write  = psel && penable && pwrite;
   assign elem_value = req_chan.element_value;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_COL_COUNT) ? CSR_DATA_W'(col_cfg_ff)
                                               : CSR_DATA_W'(row_cfg_ff);

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.rect_sum    = rsp_sum_ff;
   assign rsp_chan.query_error = rsp_err_ff;

   // counts in use: 0 acts as 1, above the maximum acts as the maximum
   always_comb begin
      if (row_cfg_ff == '0) begin
         rows_eff = RCNT_W'(1);
      end else if (RCFG_W'(row_cfg_ff) > RCFG_W'(MAX_ROWS)) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(row_cfg_ff);
      end
      if (col_cfg_ff == '0) begin
         cols_eff = CCNT_W'(1);
      end else if (CCFG_W'(col_cfg_ff) > CCFG_W'(MAX_COLS)) begin
         cols_eff = CCNT_W'(MAX_COLS);
      end else begin
         cols_eff = CCNT_W'(col_cfg_ff);
      end
   end

   // a load into a full table (or past the counts) starts a new matrix at (0,0)
   always_comb begin
      restart  = full_ff || (RCNT_W'(load_row_ff) >= rows_eff)
                         || (CCNT_W'(load_col_ff) >= cols_eff);
      ld_row   = restart ? '0 : load_row_ff;
      ld_col   = restart ? '0 : load_col_ff;
      run_base = (ld_col == '0) ? '0 : run_sum_ff;
      // running sum wraps at its own width
      run_new  = run_base + RUN_W'(elem_value);
      col_next = CCNT_W'(ld_col) + CCNT_W'(1);
      row_next = RCNT_W'(ld_row) + RCNT_W'(1);
   end

   assign query_bad = !full_ff
                   || (RQ_W'(req_chan.end_row) >= RQ_W'(rows_eff))
                   || (CQ_W'(req_chan.end_col) >= CQ_W'(cols_eff))
                   || (req_chan.start_row > req_chan.end_row)
                   || (req_chan.start_col > req_chan.end_col);

   // corners on row -1 or column -1 are skipped
   always_comb begin
      unique case (corner_ff)
         CORNER_BR: begin
            corner_row = q_er_ff;
            corner_col = q_ec_ff;
            corner_use = 1'b1;
            corner_neg = 1'b0;
         end
         CORNER_TR: begin
            corner_row = q_sr_ff - ROW_W'(1);
            corner_col = q_ec_ff;
            corner_use = (q_sr_ff != '0);
            corner_neg = 1'b1;
         end
         CORNER_BL: begin
            corner_row = q_er_ff;
            corner_col = q_sc_ff - COL_W'(1);
            corner_use = (q_sc_ff != '0);
            corner_neg = 1'b1;
         end
         CORNER_TL: begin
            corner_row = q_sr_ff - ROW_W'(1);
            corner_col = q_sc_ff - COL_W'(1);
            corner_use = (q_sr_ff != '0) && (q_sc_ff != '0);
            corner_neg = 1'b0;
         end
         default: begin
            corner_row = q_er_ff;
            corner_col = q_ec_ff;
            corner_use = 1'b0;
            corner_neg = 1'b0;
         end
      endcase
   end

   // entry above the one being written; row 0 has none
   assign above = (wr_row_ff != '0) ? rd_data_ff : '0;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      row_cfg_in   = row_cfg_ff;
      col_cfg_in   = col_cfg_ff;
      load_row_in  = load_row_ff;
      load_col_in  = load_col_ff;
      run_sum_in   = run_sum_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_err_in   = rsp_err_ff;
      wr_row_in    = wr_row_ff;
      wr_col_in    = wr_col_ff;
      q_sr_in      = q_sr_ff;
      q_sc_in      = q_sc_ff;
      q_er_in      = q_er_ff;
      q_ec_in      = q_ec_ff;
      q_err_in     = q_err_ff;
      acc_in       = acc_ff;
      term_use_in  = term_use_ff;
      term_neg_in  = term_neg_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = addr_of(corner_row, corner_col);
      mem_wdata    = above + TABLE_W'(run_sum_ff);

      // config writes must arrive only while idle (the block does not enforce this); either register restarts the load
      if (csr_write) begin
         if (paddr[2] == REG_ROW_COUNT) begin
            row_cfg_in = pwdata[CNT_W-1:0];
         end else begin
            col_cfg_in = pwdata[CNT_W-1:0];
         end
         load_row_in = '0;
         load_col_in = '0;
         run_sum_in  = '0;
         full_in     = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_LOAD) begin
                  wr_row_in  = ld_row;
                  wr_col_in  = ld_col;
                  run_sum_in = run_new;
                  full_in    = 1'b0;
                  if (col_next >= cols_eff) begin
                     load_col_in = '0;
                     if (row_next >= rows_eff) begin
                        load_row_in = '0;
                        full_in     = 1'b1;
                     end else begin
                        load_row_in = row_next[ROW_W-1:0];
                     end
                  end else begin
                     load_row_in = ld_row;
                     load_col_in = col_next[COL_W-1:0];
                  end
                  state_in = ST_LD_READ;
               end else begin
                  q_sr_in     = ROW_W'(req_chan.start_row);
                  q_sc_in     = COL_W'(req_chan.start_col);
                  q_er_in     = ROW_W'(req_chan.end_row);
                  q_ec_in     = COL_W'(req_chan.end_col);
                  q_err_in    = query_bad;
                  acc_in      = '0;
                  term_use_in = 1'b0;
                  term_neg_in = 1'b0;
                  corner_in   = CORNER_BR;
                  state_in    = query_bad ? ST_Q_DONE : ST_Q_READ;
               end
            end
         end
         ST_LD_READ: begin
            mem_re   = (wr_row_ff != '0);
            mem_addr = addr_of(wr_row_ff - ROW_W'(1), wr_col_ff);
            state_in = ST_LD_WRITE;
         end
         ST_LD_WRITE: begin
            mem_we   = 1'b1;
            mem_addr = addr_of(wr_row_ff, wr_col_ff);
            state_in = ST_IDLE;
         end
         ST_Q_READ: begin
            // fold in the corner read last cycle, issue the next one
            if (term_use_ff) begin
               acc_in = term_neg_ff ? acc_ff - rd_data_ff : acc_ff + rd_data_ff;
            end
            mem_re      = corner_use;
            term_use_in = corner_use;
            term_neg_in = corner_neg;
            corner_in   = corner_type'(corner_ff + 2'd1);
            if (corner_ff == CORNER_TL) begin
               state_in = ST_Q_LAST;
            end
         end
         ST_Q_LAST: begin
            if (term_use_ff) begin
               acc_in = term_neg_ff ? acc_ff - rd_data_ff : acc_ff + rd_data_ff;
            end
            term_use_in = 1'b0;
            state_in    = ST_Q_DONE;
         end
         ST_Q_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = q_err_ff ? '0 : acc_ff;
               rsp_err_in   = q_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         corner_ff    <= CORNER_BR;
         row_cfg_ff   <= ROW_COUNT_RESET;
         col_cfg_ff   <= COL_COUNT_RESET;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         run_sum_ff   <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         term_use_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         row_cfg_ff   <= row_cfg_in;
         col_cfg_ff   <= col_cfg_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         run_sum_ff   <= run_sum_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         term_use_ff  <= term_use_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_sum_ff  <= rsp_sum_in;
      rsp_err_ff  <= rsp_err_in;
      wr_row_ff   <= wr_row_in;
      wr_col_ff   <= wr_col_in;
      q_sr_ff     <= q_sr_in;
      q_sc_ff     <= q_sc_in;
      q_er_ff     <= q_er_in;
      q_ec_ff     <= q_ec_in;
      q_err_ff    <= q_err_in;
      acc_ff      <= acc_in;
      term_neg_ff <= term_neg_in;
   end

   // single-port table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end else if (mem_re) begin
         rd_data_ff <= table_mem[mem_addr];
      end
   end

   // ---------------------------------------------------------------- checks
   a_write_only_in_load: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_LD_WRITE))
      else $error("table write outside the load write-back");

   a_error_sum_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_sum_ff == '0))
      else $error("rejected query carries a nonzero sum");

   a_load_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (CCNT_W'(load_col_ff) < cols_eff))
      else $error("load column beyond the column count in use");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_Q_DONE))
      else $error("response raised outside query completion");

endmodule

>>> tb/summed_area_table_rect_sum_test.sv
`timescale 1ns / 1ps

module summed_area_table_rect_sum_test;
   import sat_pkg::*;

   localparam int ROWS          = DEF_MAX_ROWS;
   localparam int COLS          = DEF_MAX_COLS;
   localparam int ELEM_W        = DEF_ELEMENT_WIDTH;
   // a load keeps the block busy with no response to show for it
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 400;
   // rows used with the full column count
   localparam int WIDE_ROWS     = 4;

   typedef struct {
      kind_type                 kind;
      logic signed [ELEM_W-1:0] element;
      logic [COORD_W-1:0]       start_row;
      logic [COORD_W-1:0]       start_col;
      logic [COORD_W-1:0]       end_row;
      logic [COORD_W-1:0]       end_col;
   } table_op_type;

   typedef struct {
      logic signed [TABLE_W-1:0] sum;
      logic                      bad;
   } rect_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   sat_req_if req_if ();
   sat_rsp_if rsp_if ();

   summed_area_table_rect_sum i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // shadow of the block: prefix table, load position, row accumulator, counts
   logic signed [TABLE_W-1:0] prefix_mem [ROWS][COLS];
   int unsigned               next_row;
   int unsigned               next_col;
   logic signed [RUN_W-1:0]   row_acc;
   bit                        table_loaded;
   logic [CNT_W-1:0]          row_count_reg;
   logic [CNT_W-1:0]          col_count_reg;

   rect_result_type expected_sums [$];
   int              mismatch_count = 0;
   int unsigned     items_sent     = 0;

   // idling knobs, percent of cycles
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // long receiver hold-off, armed by a test and counted down in its own process
   int unsigned hold_cycles = 0;
   logic        hold_active = 1'b0;
   event        hold_go;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // a count of 0 acts as 1, anything past the table size acts as the size
   function automatic int unsigned count_in_use(input logic [CNT_W-1:0] cnt,
                                                input int unsigned limit);
      if (cnt == 0) return 1;
      if (32'(cnt) > limit) return limit;
      return 32'(cnt);
   endfunction

   function automatic void restart_matrix();
      next_row     = 0;
      next_col     = 0;
      row_acc      = '0;
      table_loaded = 1'b0;
   endfunction

   // update the shadow table for one accepted transfer and queue any response
   function automatic void apply_table_op(input table_op_type op);
      int unsigned               rows;
      int unsigned               cols;
      logic signed [TABLE_W-1:0] above;
      logic signed [TABLE_W-1:0] acc;
      rect_result_type           res;
      rows = count_in_use(row_count_reg, ROWS);
      cols = count_in_use(col_count_reg, COLS);
      if (op.kind == KIND_LOAD) begin
         // a load into a full table, or past a shrunk size, starts a new matrix
         if (table_loaded || next_row >= rows || next_col >= cols) restart_matrix();
         if (next_col == 0) row_acc = '0;
         row_acc = row_acc + RUN_W'(op.element);
         if (next_row > 0) above = prefix_mem[next_row - 1][next_col];
         else above = '0;
         prefix_mem[next_row][next_col] = above + TABLE_W'(row_acc);
         next_col++;
         if (next_col >= cols) begin
            next_col = 0;
            next_row++;
            if (next_row >= rows) begin
               next_row     = 0;
               table_loaded = 1'b1;
            end
         end
      end else begin
         res.sum = '0;
         res.bad = 1'b0;
         if (!table_loaded || 32'(op.end_row) >= rows || 32'(op.end_col) >= cols ||
             op.start_row > op.end_row || op.start_col > op.end_col) begin
            res.bad = 1'b1;
         end else begin
            acc = prefix_mem[op.end_row][op.end_col];
            if (op.start_row > 0) acc = acc - prefix_mem[op.start_row - 1][op.end_col];
            if (op.start_col > 0) acc = acc - prefix_mem[op.end_row][op.start_col - 1];
            if (op.start_row > 0 && op.start_col > 0)
               acc = acc + prefix_mem[op.start_row - 1][op.start_col - 1];
            res.sum = acc;
         end
         expected_sums.insert(expected_sums.size(), res);
      end
   endfunction

   // load transfers carry random coordinates, queries a random element
   function automatic table_op_type load_op(input logic signed [ELEM_W-1:0] value);
      table_op_type op;
      op.kind      = KIND_LOAD;
      op.element   = value;
      op.start_row = COORD_W'($urandom);
      op.start_col = COORD_W'($urandom);
      op.end_row   = COORD_W'($urandom);
      op.end_col   = COORD_W'($urandom);
      return op;
   endfunction

   function automatic table_op_type query_op(input int unsigned sr, input int unsigned sc,
                                             input int unsigned er, input int unsigned ec);
      table_op_type op;
      op.kind      = KIND_QUERY;
      op.element   = ELEM_W'($urandom);
      op.start_row = COORD_W'(sr);
      op.start_col = COORD_W'(sc);
      op.end_row   = COORD_W'(er);
      op.end_col   = COORD_W'(ec);
      return op;
   endfunction

   // extremes come up often enough to hit the wrap corners
   function automatic logic signed [ELEM_W-1:0] random_element();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return {1'b0, {(ELEM_W - 1){1'b1}}};
      if (pick == 1) return {1'b1, {(ELEM_W - 1){1'b0}}};
      return ELEM_W'($urandom);
   endfunction

   // rectangle inside the area in use, start not past end
   function automatic table_op_type inside_query();
      int unsigned er;
      int unsigned ec;
      er = $urandom_range(0, count_in_use(row_count_reg, ROWS) - 1);
      ec = $urandom_range(0, count_in_use(col_count_reg, COLS) - 1);
      return query_op($urandom_range(0, er), $urandom_range(0, ec), er, ec);
   endfunction

   function automatic table_op_type noise_query();
      return query_op($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 63));
   endfunction

   // offer one transfer after a random gap, valid stays up until it is accepted
   task automatic send_item(input table_op_type op);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.kind          <= op.kind;
      req_if.element_value <= op.element;
      req_if.start_row     <= op.start_row;
      req_if.start_col     <= op.start_col;
      req_if.end_row       <= op.end_row;
      req_if.end_col       <= op.end_col;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      apply_table_op(op);
      items_sent++;
   endtask

   task automatic load_elements(input int unsigned n);
      repeat (n) send_item(load_op(random_element()));
   endtask

   // stop offering, wait for every response and for a trailing load to finish
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic write_count(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      drain_block();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_ROW_COUNT) row_count_reg = value[CNT_W-1:0];
      else col_count_reg = value[CNT_W-1:0];
      restart_matrix();
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] rows,
                               input logic [CSR_DATA_W-1:0] cols);
      write_count(REG_ROW_COUNT, rows);
      write_count(REG_COL_COUNT, cols);
   endtask

   // response side: check each transfer, then pick ready for the next cycle
   always @(posedge clock) begin : rsp_monitor
      rect_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_sums.size() == 0) begin
            report_mismatch("unexpected response", longint'(rsp_if.rect_sum), longint'(0));
         end else begin
            want = expected_sums.pop_front();
            if (rsp_if.rect_sum !== want.sum)
               report_mismatch("rect_sum", longint'(rsp_if.rect_sum), longint'(want.sum));
            if (rsp_if.query_error !== want.bad)
               report_mismatch("query_error", longint'(rsp_if.query_error),
                               longint'(want.bad));
         end
      end
      rsp_if.ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (hold_cycles) @(posedge clock);
      hold_active <= 1'b0;
   end

   // right after reset the table is incomplete
   task automatic test_query_after_reset();
      send_item(query_op(0, 0, 0, 0));
   endtask

   // 2x3 matrix with extreme elements, every kind of rejected query
   task automatic test_small_matrix();
      set_geometry(2, 3);
      send_item(load_op(16'sh7fff));
      send_item(load_op(-16'sh8000));
      send_item(load_op(16'sh0000));
      send_item(query_op(0, 0, 0, 0));      // half loaded
      send_item(load_op(-16'sh0001));
      send_item(load_op(16'sh0001));
      send_item(load_op(16'sh7fff));
      send_item(query_op(0, 0, 1, 2));
      send_item(query_op(1, 2, 1, 2));
      send_item(query_op(1, 1, 1, 2));
      send_item(query_op(0, 1, 1, 1));
      send_item(query_op(0, 0, 2, 2));      // end row out of range
      send_item(query_op(0, 0, 1, 3));      // end col out of range
      send_item(query_op(1, 0, 0, 2));      // start row past end
      send_item(query_op(0, 2, 1, 1));      // start col past end
      send_item(query_op(63, 63, 63, 63));
      send_item(load_op(16'sh1234));        // load into a full table restarts it
      send_item(query_op(0, 0, 0, 0));
   endtask

   // counts of zero and above the table size
   task automatic test_count_clamp();
      set_geometry(0, 127);
      load_elements(COLS);
      send_item(query_op(0, 0, 0, 63));
      send_item(query_op(0, 17, 0, 40));
      send_item(query_op(0, 63, 0, 63));
      send_item(query_op(0, 0, 1, 0));
      set_geometry(100, 0);
      load_elements(ROWS);
      send_item(query_op(0, 0, 63, 0));
      send_item(query_op(63, 0, 63, 0));
      send_item(query_op(5, 0, 30, 0));
      send_item(query_op(0, 0, 0, 1));
   endtask

   // full column count, corners at the last row and column in use
   task automatic test_full_width();
      set_geometry(WIDE_ROWS, COLS);
      load_elements(WIDE_ROWS * COLS);
      send_item(query_op(0, 0, WIDE_ROWS - 1, 63));
      send_item(query_op(WIDE_ROWS - 1, 63, WIDE_ROWS - 1, 63));
      send_item(query_op(0, 63, WIDE_ROWS - 1, 63));
      send_item(query_op(WIDE_ROWS - 1, 0, WIDE_ROWS - 1, 63));
      send_item(query_op(0, 0, WIDE_ROWS, 63));   // end row out of range
      repeat (20) send_item(inside_query());
      repeat (5) send_item(noise_query());
   endtask

   // receiver holds off while queries keep coming, input must back up
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_geometry(3, 4);
      load_elements(12);
      hold_cycles = HOLD_CYCLES;
      -> hold_go;
      repeat (24) send_item(inside_query());
      drain_block();
   endtask

   // rounds of: new geometry, full load (sometimes twice), burst of queries
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned n_items);
      int unsigned           target;
      int unsigned           cells;
      int unsigned           early;
      int unsigned           passes;
      logic [CSR_DATA_W-1:0] row_word;
      logic [CSR_DATA_W-1:0] col_word;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      target = items_sent + n_items;
      while (items_sent < target) begin
         // upper bits of the write data are noise the register must drop
         row_word = $urandom;
         col_word = $urandom;
         row_word[CNT_W-1:0] = CNT_W'($urandom_range(1, 6));
         col_word[CNT_W-1:0] = CNT_W'($urandom_range(1, 6));
         if ($urandom_range(0, 9) == 0) row_word[CNT_W-1:0] = CNT_W'($urandom_range(0, 127));
         else if ($urandom_range(0, 9) == 0)
            col_word[CNT_W-1:0] = CNT_W'($urandom_range(0, 127));
         set_geometry(row_word, col_word);
         cells = count_in_use(row_count_reg, ROWS) * count_in_use(col_count_reg, COLS);
         passes = ($urandom_range(0, 3) == 0) ? 2 : 1;
         repeat (passes) begin
            // sometimes slip a query into the middle of the load
            early = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cells - 1) : cells;
            for (int unsigned i = 0; i < cells; i++) begin
               if (i == early) send_item(inside_query());
               send_item(load_op(random_element()));
            end
            repeat ($urandom_range(4, 20))
               send_item(($urandom_range(0, 99) < 85) ? inside_query() : noise_query());
         end
      end
      drain_block();
   endtask

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.kind          <= KIND_LOAD;
      req_if.element_value <= '0;
      req_if.start_row     <= '0;
      req_if.start_col     <= '0;
      req_if.end_row       <= '0;
      req_if.end_col       <= '0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      row_count_reg = ROW_COUNT_RESET;
      col_count_reg = COL_COUNT_RESET;
      restart_matrix();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_query_after_reset();
      test_small_matrix();
      test_count_clamp();
      test_full_width();
      test_output_backpressure();
      test_random_traffic(0, 0, 170);
      test_random_traffic(68, 0, 170);
      test_random_traffic(0, 68, 170);
      test_random_traffic(37, 37, 170);

      drain_block();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
